// ===== hw/rtl/tpcm_pkg.sv =====
// Shared types, constants and helper functions of the continuity monitor.
package tpcm_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotBits = $clog2(TableEntries);
  localparam int unsigned CountBits = 24;
  localparam int unsigned KeyBits = 79;
  localparam int unsigned CntWordBits = 4 + 2 * CountBits;
  localparam logic [7:0] SyncValue = 8'h47;
  localparam logic [23:0] PesStart = 24'h000001;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OpProcess = 2'd0,
    OpClear = 2'd1,
    OpRead = 2'd2,
    OpNone = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KindUnknown = 2'd0,
    KindAudio = 2'd1,
    KindVideo = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle, StScan, StCheck, StRead, StUpd, StClear, StOut
  } back_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] dest_addr;
    logic [31:0] src_addr;
    logic [7:0] sync_byte;
    logic [7:0] hdr_byte1;
    logic [7:0] hdr_byte2;
    logic [7:0] hdr_byte3;
    logic [23:0] pes_prefix;
    logic [7:0] stream_id;
    logic [5:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic sync_ok;
    logic hit;
    logic new_entry;
    logic table_full;
    logic [5:0] slot;
    logic [12:0] pid;
    logic [1:0] stream_kind;
    logic [3:0] lost_now;
    logic [23:0] packet_count;
    logic [23:0] lost_count;
  } out_item_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    opcode_e op;
    logic sync_ok;
    logic may_insert;
    logic [31:0] dest;
    logic [31:0] src;
    logic [12:0] pid;
    logic [3:0] cc;
    kind_e kind;
    logic [5:0] index;
  } cmd_t;

  function automatic kind_e kind_of(logic [7:0] sid);
    kind_e k;
    k = KindUnknown;
    if (sid >= 8'hC0 && sid <= 8'hDF) k = KindAudio;
    else if (sid >= 8'hE0 && sid <= 8'hEF) k = KindVideo;
    return k;
  endfunction

  function automatic logic [CountBits-1:0] sat_add(logic [CountBits-1:0] a,
                                                    logic [3:0] b);
    logic [CountBits:0] r;
    r = {1'b0, a} + {{(CountBits - 3){1'b0}}, b};
    return r[CountBits] ? CountMax : r[CountBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/tpcm_ram.sv =====
// Generic single-port RAM with registered read.
module tpcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/tpcm_front.sv =====
// Front part: accepts input items, decodes the header and queues commands.
module tpcm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  tpcm_pkg::in_item_t  item_i,
  output logic                cmd_valid_o,
  output tpcm_pkg::cmd_t      cmd_o,
  input  logic                cmd_take_i
);
  tpcm_pkg::cmd_t q_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  tpcm_pkg::cmd_t dec;
  logic do_push, do_pop;

  always_comb begin
    dec.op = tpcm_pkg::opcode_e'(item_i.opcode);
    dec.sync_ok = (item_i.sync_byte == tpcm_pkg::SyncValue);
    dec.may_insert = item_i.hdr_byte1[6] && (item_i.pes_prefix == tpcm_pkg::PesStart);
    dec.dest = item_i.dest_addr;
    dec.src = item_i.src_addr;
    dec.pid = {item_i.hdr_byte1[4:0], item_i.hdr_byte2};
    dec.cc = item_i.hdr_byte3[3:0];
    dec.kind = tpcm_pkg::kind_of(item_i.stream_id);
    dec.index = item_i.entry_index;
  end

  assign full_o = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop = cmd_take_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("command queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !cmd_valid_o) else $error("valid from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> (cnt_q == 2'd2)) else $error("full queue lost a command");
endmodule

// ===== hw/rtl/tpcm_back.sv =====
// Back part: sequential table search, update, entry read, clear sweep and result register.
module tpcm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  tpcm_pkg::cmd_t      cmd_i,
  output logic                cmd_take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output tpcm_pkg::out_item_t result_o
);
  localparam int unsigned SB = tpcm_pkg::SlotBits;
  localparam int unsigned CB = tpcm_pkg::CountBits;

  tpcm_pkg::back_state_e st_q, st_d;
  tpcm_pkg::cmd_t cmd_q;
  logic [tpcm_pkg::TableEntries-1:0] valid_q;
  logic [SB-1:0] idx_q, idx_d;
  logic [SB-1:0] slot_q;
  logic [SB:0] free_q;
  logic new_q;
  logic res_valid_q;
  tpcm_pkg::out_item_t res_q, res_d;
  tpcm_pkg::out_item_t out_q;
  logic take;

  logic key_we, cnt_we;
  logic [SB-1:0] addr;
  logic [tpcm_pkg::KeyBits-1:0] key_wdata, key_rdata;
  logic [tpcm_pkg::CntWordBits-1:0] cnt_wdata, cnt_rdata;
  logic [1:0] rd_kind;
  logic [12:0] rd_pid;
  logic [3:0] rd_cc, d, lost;
  logic [CB-1:0] rd_pk, rd_lo, new_pk, new_lo;

  tpcm_ram #(.Width(tpcm_pkg::KeyBits), .Depth(tpcm_pkg::TableEntries)) u_key (
    .clk_i, .we_i(key_we), .addr_i(addr), .wdata_i(key_wdata), .rdata_o(key_rdata));
  tpcm_ram #(.Width(tpcm_pkg::CntWordBits), .Depth(tpcm_pkg::TableEntries)) u_cnt (
    .clk_i, .we_i(cnt_we), .addr_i(addr), .wdata_i(cnt_wdata), .rdata_o(cnt_rdata));

  assign rd_kind = key_rdata[1:0];
  assign rd_pid = key_rdata[14:2];
  assign {rd_cc, rd_pk, rd_lo} = cnt_rdata;
  assign d = cmd_q.cc - rd_cc;
  assign lost = (d > 4'd1) ? d - 4'd1 : 4'd0;
  assign new_pk = tpcm_pkg::sat_add(rd_pk, 4'd1);
  assign new_lo = tpcm_pkg::sat_add(rd_lo, lost);
  assign take = (st_q == tpcm_pkg::StIdle) && cmd_valid_i;
  assign cmd_take_o = take;
  assign empty_o = !res_valid_q;
  assign result_o = out_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      tpcm_pkg::StIdle: if (take) begin
        unique case (cmd_i.op)
          tpcm_pkg::OpProcess: st_d = cmd_i.sync_ok ? tpcm_pkg::StScan : tpcm_pkg::StOut;
          tpcm_pkg::OpClear: st_d = tpcm_pkg::StClear;
          tpcm_pkg::OpRead: st_d = tpcm_pkg::StRead;
          default: st_d = tpcm_pkg::StOut;
        endcase
      end
      tpcm_pkg::StScan: st_d = tpcm_pkg::StCheck;
      tpcm_pkg::StCheck: begin
        if (valid_q[idx_q] && key_rdata[tpcm_pkg::KeyBits-1:2] ==
            {cmd_q.dest, cmd_q.src, cmd_q.pid}) st_d = tpcm_pkg::StUpd;
        else if (idx_q == SB'(tpcm_pkg::TableEntries - 1)) begin
          // The last slot may itself be the lowest free one.
          st_d = (cmd_q.may_insert && (!free_q[SB] || !valid_q[idx_q])) ?
                 tpcm_pkg::StUpd : tpcm_pkg::StOut;
        end else st_d = tpcm_pkg::StScan;
      end
      tpcm_pkg::StRead: st_d = tpcm_pkg::StOut;
      tpcm_pkg::StUpd: st_d = tpcm_pkg::StOut;
      tpcm_pkg::StClear: if (idx_q == SB'(tpcm_pkg::TableEntries - 1)) st_d = tpcm_pkg::StOut;
      tpcm_pkg::StOut: if (!res_valid_q) st_d = tpcm_pkg::StIdle;
      default: st_d = tpcm_pkg::StIdle;
    endcase
  end

  // Memory controls and result formation.
  always_comb begin
    key_we = 1'b0;
    cnt_we = 1'b0;
    addr = idx_q;
    idx_d = idx_q;
    key_wdata = {cmd_q.dest, cmd_q.src, cmd_q.pid, cmd_q.kind};
    cnt_wdata = {cmd_q.cc, new_pk, new_lo};
    res_d = res_q;
    unique case (st_q)
      tpcm_pkg::StIdle: begin
        idx_d = '0;
        res_d = '0;
        if (take && cmd_i.op == tpcm_pkg::OpRead) begin
          idx_d = cmd_i.index[SB-1:0];
          addr = cmd_i.index[SB-1:0];
        end
      end
      tpcm_pkg::StScan: ;
      tpcm_pkg::StCheck: begin
        if (!(valid_q[idx_q] && key_rdata[tpcm_pkg::KeyBits-1:2] ==
            {cmd_q.dest, cmd_q.src, cmd_q.pid})) begin
          idx_d = idx_q + 1'b1;
          addr = free_q[SB-1:0];
          if (idx_q == SB'(tpcm_pkg::TableEntries - 1) && cmd_q.may_insert &&
              free_q[SB] && valid_q[idx_q]) begin
            res_d.table_full = 1'b1;
          end
        end
        res_d.sync_ok = 1'b1;
        res_d.pid = cmd_q.pid;
      end
      tpcm_pkg::StRead: ;
      tpcm_pkg::StUpd: ;
      tpcm_pkg::StClear: begin
        cnt_we = 1'b1;
        cnt_wdata = '0;
        idx_d = idx_q + 1'b1;
      end
      tpcm_pkg::StOut: ;
      default: ;
    endcase
    if (st_q == tpcm_pkg::StUpd) begin
      addr = slot_q;
      cnt_we = 1'b1;
      if (new_q) begin
        key_we = 1'b1;
        cnt_wdata = {cmd_q.cc, CB'(1), CB'(cmd_q.cc > 4'd1 ? cmd_q.cc - 4'd1 : 4'd0)};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tpcm_pkg::StIdle;
      idx_q <= '0;
      valid_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      out_q <= '0;
      slot_q <= '0;
      free_q <= '0;
      new_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      if (res_valid_q && pop_i) res_valid_q <= 1'b0;
      if (st_q == tpcm_pkg::StIdle) begin
        res_q <= res_d;
        free_q <= {1'b1, SB'(0)};
        new_q <= 1'b0;
      end
      if (st_q == tpcm_pkg::StCheck) begin
        res_q <= res_d;
        if (!valid_q[idx_q] && free_q[SB]) free_q <= {1'b0, idx_q};
        if (valid_q[idx_q] && key_rdata[tpcm_pkg::KeyBits-1:2] ==
            {cmd_q.dest, cmd_q.src, cmd_q.pid}) begin
          slot_q <= idx_q;
        end else if (idx_q == SB'(tpcm_pkg::TableEntries - 1)) begin
          if (cmd_q.may_insert) begin
            if (!free_q[SB]) begin
              slot_q <= free_q[SB-1:0];
              new_q <= 1'b1;
            end else if (!valid_q[idx_q]) begin
              // Last slot itself is the only free one.
              slot_q <= idx_q;
              new_q <= 1'b1;
            end
          end
        end
      end
      if (st_q == tpcm_pkg::StRead) begin
        res_q.slot <= cmd_q.index;
        if (valid_q[idx_q]) begin
          res_q.hit <= 1'b1;
          res_q.pid <= rd_pid;
          res_q.stream_kind <= rd_kind;
          res_q.packet_count <= rd_pk;
          res_q.lost_count <= rd_lo;
        end
      end
      if (st_q == tpcm_pkg::StUpd) begin
        valid_q[slot_q] <= 1'b1;
        res_q.hit <= 1'b1;
        res_q.new_entry <= new_q;
        res_q.slot <= 6'(slot_q);
        res_q.pid <= cmd_q.pid;
        if (new_q) begin
          res_q.stream_kind <= cmd_q.kind;
          res_q.lost_now <= (cmd_q.cc > 4'd1) ? cmd_q.cc - 4'd1 : 4'd0;
          res_q.packet_count <= CB'(1);
          res_q.lost_count <= CB'((cmd_q.cc > 4'd1) ? cmd_q.cc - 4'd1 : 4'd0);
        end else begin
          res_q.stream_kind <= rd_kind;
          res_q.lost_now <= lost;
          res_q.packet_count <= new_pk;
          res_q.lost_count <= new_lo;
        end
      end
      // The output register frees the working result for the next command.
      if (st_q == tpcm_pkg::StOut && !res_valid_q) begin
        res_valid_q <= 1'b1;
        out_q <= res_q;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == tpcm_pkg::StUpd) |=> valid_q[$past(slot_q)])
    else $error("updated slot not valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !pop_i) |=> res_valid_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> st_q == tpcm_pkg::StIdle) else $error("take outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_we) |-> (st_q == tpcm_pkg::StUpd && new_q)) else $error("stray key write");
endmodule

// ===== hw/rtl/ts_pid_continuity_monitor.sv =====
// Top level of the transport stream continuity monitor.
// Usage:
//   Input queue side: drive in_item_i and raise push; a transfer happens when
//   full is low. Two decoded commands can wait in front.
//   Result queue side: while empty is low, out_item_o holds the oldest result;
//   raise pop to take it. One result is produced per input item.
// Operation:
//   A process command scans the 64-entry table slot by slot, each slot in
//   two steps (address, then compare against the registered RAM read); a
//   bad sync byte or an unused opcode goes straight to the result, and a
//   clear sweeps the counter RAM one slot per cycle. Commands are carried
//   out one at a time, so the scan through the key RAM sets the rate.
// Reset clears all valid bits and the queues; table contents other than the
// valid bits are unknown but never read while invalid.
// While the result is not taken, the back part finishes the command in hand
// and then holds; the front queue keeps accepting until its two places are
// full.
module ts_pid_continuity_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tpcm_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output tpcm_pkg::out_item_t out_item_o
);
  logic cmd_valid, cmd_take;
  tpcm_pkg::cmd_t cmd;

  tpcm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item_i),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take));

  tpcm_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .empty_o(empty), .pop_i(pop), .result_o(out_item_o));
endmodule

// ===== test/tb_ts_pid_continuity_monitor.sv =====
// Testbench of the transport stream continuity monitor: random and directed headers.
module tb_ts_pid_continuity_monitor;

  localparam int NumSlots = 64;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic empty;
  logic pop;
  tpcm_pkg::in_item_t in_item_i;
  tpcm_pkg::out_item_t out_item_o;

  ts_pid_continuity_monitor dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .out_item_o(out_item_o)
  );

  // Predicted flow table.
  logic        tbl_valid [NumSlots];
  logic [31:0] tbl_dest [NumSlots];
  logic [31:0] tbl_src [NumSlots];
  logic [12:0] tbl_pid [NumSlots];
  logic [1:0]  tbl_kind [NumSlots];
  logic [3:0]  tbl_cc [NumSlots];
  logic [23:0] tbl_pkts [NumSlots];
  logic [23:0] tbl_lost [NumSlots];

  tpcm_pkg::out_item_t expected_q[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;

  // Known flows used to build well-formed sequences.
  logic [31:0] flow_dest [8];
  logic [31:0] flow_src [8];
  logic [12:0] flow_pid [8];
  logic [3:0]  flow_cc [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("FAIL ts_pid_continuity_monitor");
    $finish;
  end

  function automatic logic [23:0] add_sat(logic [23:0] a, logic [3:0] b);
    logic [24:0] r;
    r = {1'b0, a} + 25'(b);
    return r[24] ? 24'hFFFFFF : r[23:0];
  endfunction

  function automatic logic [1:0] stream_class(logic [7:0] sid);
    if (sid >= 8'hC0 && sid <= 8'hDF) return tpcm_pkg::KindAudio;
    if (sid >= 8'hE0 && sid <= 8'hEF) return tpcm_pkg::KindVideo;
    return tpcm_pkg::KindUnknown;
  endfunction

  function automatic tpcm_pkg::out_item_t entry_view(int k);
    tpcm_pkg::out_item_t r;
    r = '0;
    r.hit = 1'b1;
    r.slot = 6'(k);
    r.pid = tbl_pid[k];
    r.stream_kind = tbl_kind[k];
    r.packet_count = tbl_pkts[k];
    r.lost_count = tbl_lost[k];
    return r;
  endfunction

  function automatic tpcm_pkg::out_item_t monitor_step(tpcm_pkg::in_item_t it);
    tpcm_pkg::out_item_t r;
    logic [12:0] p;
    logic [3:0] cc;
    logic [3:0] d;
    logic [3:0] lost;
    int k;
    r = '0;
    k = -1;
    case (tpcm_pkg::opcode_e'(it.opcode))
      tpcm_pkg::OpProcess: begin
        if (it.sync_byte == tpcm_pkg::SyncValue) begin
          p = {it.hdr_byte1[4:0], it.hdr_byte2};
          cc = it.hdr_byte3[3:0];
          r.sync_ok = 1'b1;
          r.pid = p;
          for (int i = 0; i < NumSlots; i++)
            if (k < 0 && tbl_valid[i] && tbl_dest[i] == it.dest_addr &&
                tbl_src[i] == it.src_addr && tbl_pid[i] == p) k = i;
          if (k < 0 && it.hdr_byte1[6] && it.pes_prefix == tpcm_pkg::PesStart) begin
            for (int i = 0; i < NumSlots; i++)
              if (k < 0 && !tbl_valid[i]) k = i;
            if (k < 0) begin
              r.table_full = 1'b1;
            end else begin
              tbl_valid[k] = 1'b1;
              tbl_dest[k] = it.dest_addr;
              tbl_src[k] = it.src_addr;
              tbl_pid[k] = p;
              tbl_kind[k] = stream_class(it.stream_id);
              tbl_cc[k] = '0;
              tbl_pkts[k] = '0;
              tbl_lost[k] = '0;
              r.new_entry = 1'b1;
            end
          end
          if (k >= 0) begin
            d = cc - tbl_cc[k];
            lost = (d > 4'd1) ? d - 4'd1 : 4'd0;
            tbl_pkts[k] = add_sat(tbl_pkts[k], 4'd1);
            tbl_lost[k] = add_sat(tbl_lost[k], lost);
            tbl_cc[k] = cc;
            r = entry_view(k) | r;
            r.lost_now = lost;
          end
        end
      end
      tpcm_pkg::OpClear: begin
        for (int i = 0; i < NumSlots; i++) begin
          tbl_cc[i] = '0;
          tbl_pkts[i] = '0;
          tbl_lost[i] = '0;
        end
      end
      tpcm_pkg::OpRead: begin
        if (tbl_valid[it.entry_index]) r = entry_view(it.entry_index);
        r.slot = it.entry_index;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Push stays high after a transfer until the next falling edge decides
  // whether a new item follows or the sender idles.
  task automatic send_item(tpcm_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(monitor_step(it));
  endtask

  initial begin : result_checker
    tpcm_pkg::out_item_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item_o.slot), 0);
        end else begin
          w = expected_q.pop_front();
          if (out_item_o.sync_ok !== w.sync_ok)
            report_mismatch("sync_ok", 32'(out_item_o.sync_ok), 32'(w.sync_ok));
          if (out_item_o.hit !== w.hit)
            report_mismatch("hit", 32'(out_item_o.hit), 32'(w.hit));
          if (out_item_o.new_entry !== w.new_entry)
            report_mismatch("new_entry", 32'(out_item_o.new_entry), 32'(w.new_entry));
          if (out_item_o.table_full !== w.table_full)
            report_mismatch("table_full", 32'(out_item_o.table_full), 32'(w.table_full));
          if (out_item_o.slot !== w.slot)
            report_mismatch("slot", 32'(out_item_o.slot), 32'(w.slot));
          if (out_item_o.pid !== w.pid)
            report_mismatch("pid", 32'(out_item_o.pid), 32'(w.pid));
          if (out_item_o.stream_kind !== w.stream_kind)
            report_mismatch("stream_kind", 32'(out_item_o.stream_kind),
                            32'(w.stream_kind));
          if (out_item_o.lost_now !== w.lost_now)
            report_mismatch("lost_now", 32'(out_item_o.lost_now), 32'(w.lost_now));
          if (out_item_o.packet_count !== w.packet_count)
            report_mismatch("packet_count", 32'(out_item_o.packet_count),
                            32'(w.packet_count));
          if (out_item_o.lost_count !== w.lost_count)
            report_mismatch("lost_count", 32'(out_item_o.lost_count),
                            32'(w.lost_count));
        end
      end
    end
  end

  initial begin : pop_driver
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tpcm_pkg::in_item_t blank_item(logic [1:0] op);
    tpcm_pkg::in_item_t it;
    it = '0;
    it.opcode = op;
    return it;
  endfunction

  function automatic tpcm_pkg::in_item_t flow_packet(int f, bit start, logic [7:0] sid);
    tpcm_pkg::in_item_t it;
    it = blank_item(tpcm_pkg::OpProcess);
    it.dest_addr = flow_dest[f];
    it.src_addr = flow_src[f];
    it.sync_byte = tpcm_pkg::SyncValue;
    it.hdr_byte1 = {1'($urandom), start, 1'($urandom), flow_pid[f][12:8]};
    it.hdr_byte2 = flow_pid[f][7:0];
    it.hdr_byte3 = {4'($urandom), flow_cc[f]};
    it.pes_prefix = start ? tpcm_pkg::PesStart : 24'($urandom);
    it.stream_id = sid;
    return it;
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    tpcm_pkg::in_item_t it;
    // Bad sync, opcode 3, read of an empty slot.
    it = flow_packet(0, 1'b1, 8'hC0);
    it.sync_byte = 8'h46;
    send_item(it);
    send_item(blank_item(tpcm_pkg::OpNone));
    it = blank_item(tpcm_pkg::OpRead);
    it.entry_index = 6'd63;
    send_item(it);
    // Insert audio, video and unknown flows, with field extremes.
    flow_dest[0] = '1; flow_src[0] = '1; flow_pid[0] = '1; flow_cc[0] = 4'd1;
    send_item(flow_packet(0, 1'b1, 8'hDF));
    flow_dest[1] = '0; flow_src[1] = '0; flow_pid[1] = '0; flow_cc[1] = 4'd15;
    send_item(flow_packet(1, 1'b1, 8'hE0));
    flow_dest[2] = 32'h0A000001; flow_src[2] = 32'hC0A80001; flow_pid[2] = 13'h100;
    flow_cc[2] = 4'd0;
    send_item(flow_packet(2, 1'b1, 8'hF0));
    // In sequence, duplicate, and a gap.
    flow_cc[0] = 4'd2; send_item(flow_packet(0, 1'b0, 8'h00));
    send_item(flow_packet(0, 1'b0, 8'h00));
    flow_cc[0] = 4'd1; send_item(flow_packet(0, 1'b0, 8'h00));
    // Unknown flow without PES start.
    it = flow_packet(2, 1'b1, 8'hEF);
    it.src_addr = 32'h12345678;
    it.pes_prefix = 24'hFFFFFF;
    send_item(it);
    it = blank_item(tpcm_pkg::OpRead); it.entry_index = 6'd0; send_item(it);
    it.entry_index = 6'd1; send_item(it);
    send_item(blank_item(tpcm_pkg::OpClear));
    it.entry_index = 6'd0; send_item(it);
    flow_cc[0] = 4'd5; send_item(flow_packet(0, 1'b0, 8'h00));
  endtask

  task automatic test_random(int count);
    tpcm_pkg::in_item_t it;
    logic [159:0] raw;
    int f;
    for (int n = 0; n < count; n++) begin
      f = $urandom_range(7);
      case ($urandom_range(19))
        0: begin
          raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
          it = raw[$bits(tpcm_pkg::in_item_t)-1:0];
          it.opcode = 2'($urandom);
          send_item(it);
        end
        1: send_item(blank_item(tpcm_pkg::OpClear));
        2, 3: begin
          it = blank_item(tpcm_pkg::OpRead);
          it.entry_index = 6'($urandom);
          send_item(it);
        end
        4: begin
          flow_dest[f] = $urandom; flow_src[f] = $urandom;
          flow_pid[f] = 13'($urandom); flow_cc[f] = 4'($urandom);
          send_item(flow_packet(f, 1'b1, 8'($urandom_range(8'hBC, 8'hFF))));
        end
        default: begin
          case ($urandom_range(5))
            0: flow_cc[f] = 4'($urandom);
            1: ;
            default: flow_cc[f] = flow_cc[f] + 4'd1;
          endcase
          send_item(flow_packet(f, 1'($urandom), 8'($urandom)));
        end
      endcase
    end
  endtask

  // Fill the table past its size with distinct flows.
  task automatic test_table_full();
    tpcm_pkg::in_item_t it;
    for (int n = 0; n < NumSlots + 4; n++) begin
      it = flow_packet(0, 1'b1, 8'hE5);
      it.dest_addr = 32'hE0000000 + n;
      send_item(it);
    end
  endtask

  // Hold the result side off so the input queue fills and stalls.
  task automatic test_back_pressure();
    int held;
    recv_hold = 1'b1;
    fork
      begin
        held = 0;
        while (held < 3000) begin
          @(posedge clk_i);
          held++;
        end
        recv_hold = 1'b0;
      end
      test_random(8);
    join
  endtask

  initial begin
    errors = 0;
    recv_hold = 1'b0;
    push = 1'b0;
    in_item_i = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      tbl_valid[i] = 1'b0; tbl_cc[i] = '0; tbl_pkts[i] = '0; tbl_lost[i] = '0;
      tbl_dest[i] = '0; tbl_src[i] = '0; tbl_pid[i] = '0; tbl_kind[i] = '0;
    end
    for (int f = 0; f < 8; f++) begin
      flow_dest[f] = $urandom; flow_src[f] = $urandom;
      flow_pid[f] = 13'($urandom); flow_cc[f] = '0;
    end
    send_idle_pct = 9;
    recv_idle_pct = 70;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(150);
    wait_drained();
    send_idle_pct = 70;
    recv_idle_pct = 9;
    test_back_pressure();
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    test_table_full();
    test_random(60);
    wait_drained();
    repeat (300) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS ts_pid_continuity_monitor");
    end else begin
      $display("FAIL ts_pid_continuity_monitor");
    end
    $finish;
  end
endmodule
